// ===== src/ascii_integer_parser_macros.svh =====
// Assertion macros for the ASCII integer parser.
`ifndef ASCII_INTEGER_PARSER_MACROS_SVH
`define ASCII_INTEGER_PARSER_MACROS_SVH
`ifndef SYNTHESIS
`define AIP_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define AIP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define AIP_ASSERT_IMPLY(lbl, ante, cons, msg)
`define AIP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== src/aip_pkg.sv =====
// Shared types and constants of the ASCII integer parser.
package aip_pkg;

	localparam int RES_W = 64;
	localparam int POS_W = 16;
	localparam int OFFSET_W = 16;
	localparam int CHAR_W = 8;
	localparam int BASE_W = 6;
	localparam int DIGIT_W = 6;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 6;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_BASE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_MODE = 1'd1;

	typedef enum logic [1:0] {
		ST_OK,
		ST_NO_DIGITS,
		ST_OVERFLOW,
		ST_BAD_BASE
	} status_t;

	typedef enum logic [2:0] {
		PH_SPACE,
		PH_SIGNED,
		PH_ZERO,
		PH_HEXPFX,
		PH_DIGITS,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic [DIGIT_W-1:0] digit;
		logic               alnum;
		logic               space;
		logic               plus;
		logic               minus;
		logic               zero;
		logic               hex_x;
		logic               last;
	} cls_t;

endpackage

// ===== src/aip_if.sv =====
// Channel interfaces of the ASCII integer parser.
interface aip_char_if;
	logic                      valid;
	logic                      ready;
	logic [aip_pkg::CHAR_W-1:0] char_code;
	logic                      last_char;

	modport source(output valid, char_code, last_char, input ready);
	modport sink(input valid, char_code, last_char, output ready);
endinterface

interface aip_result_if;
	logic                         valid;
	logic                         ready;
	logic [aip_pkg::RES_W-1:0]    value;
	logic [1:0]                   status;
	logic [aip_pkg::OFFSET_W-1:0] end_offset;
	logic                         stopped_early;

	modport source(output valid, value, status, end_offset, stopped_early, input ready);
	modport sink(input valid, value, status, end_offset, stopped_early, output ready);
endinterface

// ===== src/aip_front.sv =====
// Front end: accepts characters and classifies them for the parse engine.
module aip_front (
	aip_char_if.sink          chars,
	input  logic              full,
	output logic              push,
	output aip_pkg::cls_t     item
);

	localparam logic [aip_pkg::CHAR_W-1:0] CH_TAB   = 8'd9;
	localparam logic [aip_pkg::CHAR_W-1:0] CH_CR    = 8'd13;
	localparam logic [aip_pkg::CHAR_W-1:0] CH_SPACE = 8'd32;
	localparam logic [aip_pkg::CHAR_W-1:0] CH_PLUS  = 8'd43;
	localparam logic [aip_pkg::CHAR_W-1:0] CH_MINUS = 8'd45;
	localparam logic [aip_pkg::CHAR_W-1:0] CH_0     = 8'd48;
	localparam logic [aip_pkg::CHAR_W-1:0] CH_9     = 8'd57;
	localparam logic [aip_pkg::CHAR_W-1:0] CH_UA    = 8'd65;
	localparam logic [aip_pkg::CHAR_W-1:0] CH_UX    = 8'd88;
	localparam logic [aip_pkg::CHAR_W-1:0] CH_UZ    = 8'd90;
	localparam logic [aip_pkg::CHAR_W-1:0] CH_LA    = 8'd97;
	localparam logic [aip_pkg::CHAR_W-1:0] CH_LX    = 8'd120;
	localparam logic [aip_pkg::CHAR_W-1:0] CH_LZ    = 8'd122;
	localparam logic [aip_pkg::CHAR_W-1:0] LETTER_OFS = 8'd10;

	logic [aip_pkg::CHAR_W-1:0] c;
	logic [aip_pkg::CHAR_W-1:0] dec;

	assign c = chars.char_code;
	assign chars.ready = !full;
	assign push = chars.valid && !full;

	always_comb begin
		dec = '0;
		item.alnum = 1'b1;
		if (c >= CH_0 && c <= CH_9) begin
			dec = c - CH_0;
		end else if (c >= CH_UA && c <= CH_UZ) begin
			dec = c - CH_UA + LETTER_OFS;
		end else if (c >= CH_LA && c <= CH_LZ) begin
			dec = c - CH_LA + LETTER_OFS;
		end else begin
			item.alnum = 1'b0;
		end
		item.digit = dec[aip_pkg::DIGIT_W-1:0];
		item.space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
		item.plus  = (c == CH_PLUS);
		item.minus = (c == CH_MINUS);
		item.zero  = (c == CH_0);
		item.hex_x = (c == CH_UX) || (c == CH_LX);
		item.last  = chars.last_char;
	end

endmodule

// ===== src/aip_queue.sv =====
// Short queue of classified characters between front end and parse engine.
module aip_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  aip_pkg::cls_t push_item,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output aip_pkg::cls_t head
);

	localparam int PTR_W = $clog2(aip_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(aip_pkg::QUEUE_DEPTH + 1);

	aip_pkg::cls_t    mem_q [aip_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == CNT_W'(aip_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/aip_back.sv =====
// Parse engine: phase sequencer, digit accumulator, result stage and output register.
`include "ascii_integer_parser_macros.svh"
module aip_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         head_valid,
	input  aip_pkg::cls_t                head,
	output logic                         pop,
	input  logic [aip_pkg::BASE_W-1:0]   number_base,
	input  logic                         signed_mode,
	aip_result_if.source                 results
);

	localparam int RES_W = aip_pkg::RES_W;
	localparam int POS_W = aip_pkg::POS_W;
	localparam int BASE_W = aip_pkg::BASE_W;
	localparam int PROD_W = RES_W + BASE_W + 1;
	localparam logic [BASE_W-1:0] BASE_MIN = 6'd2;
	localparam logic [BASE_W-1:0] BASE_MAX = 6'd36;
	localparam logic [BASE_W-1:0] BASE_ONE = 6'd1;
	localparam logic [BASE_W-1:0] BASE_OCT = 6'd8;
	localparam logic [BASE_W-1:0] BASE_DEC = 6'd10;
	localparam logic [BASE_W-1:0] BASE_HEX = 6'd16;

	function automatic logic [RES_W-1:0] mag_limit(input logic sgn, input logic neg);
		if (!sgn) begin
			mag_limit = '1;
		end else if (neg) begin
			mag_limit = {1'b1, {(RES_W-1){1'b0}}};
		end else begin
			mag_limit = {1'b0, {(RES_W-1){1'b1}}};
		end
	endfunction

	function automatic logic pos_sat_inc_en(input logic [POS_W-1:0] p);
		pos_sat_inc_en = (p != '1);
	endfunction

	function automatic logic [POS_W-1:0] pos_inc(input logic [POS_W-1:0] p);
		pos_inc = pos_sat_inc_en(p) ? p + 1'b1 : p;
	endfunction

	function automatic logic base_bad(input logic [BASE_W-1:0] b);
		base_bad = (b == BASE_ONE) || (b > BASE_MAX);
	endfunction

	aip_pkg::phase_t      phase_q, phase_d;
	logic [RES_W-1:0]     acc_q, acc_d;
	logic                 neg_q, neg_d;
	logic [BASE_W-1:0]    base_q, base_d;
	logic [POS_W-1:0]     pos_q, pos_d;
	logic [POS_W-1:0]     endp_q, endp_d;
	logic                 ovf_q, ovf_d;

	logic                 begin_num;
	logic                 try_num;
	logic                 take;
	logic [BASE_W-1:0]    base_use;
	logic [RES_W-1:0]     lim;
	logic [PROD_W-1:0]    prod;

	logic                 s2_valid_q;
	logic [RES_W-1:0]     acc_s2;
	logic                 neg_s2;
	logic                 ovf_s2;
	logic                 sgn_s2;
	logic                 bad_s2;
	logic [POS_W-1:0]     end_s2;
	logic [POS_W-1:0]     cnt_s2;
	logic                 s2_free;

	logic [RES_W-1:0]     lim_s2;
	logic [RES_W-1:0]     fin_value;
	aip_pkg::status_t     fin_status;
	logic [POS_W-1:0]     fin_end;

	logic                 out_load;
	logic                 out_valid_q;
	logic [RES_W-1:0]     value_q;
	aip_pkg::status_t     status_q;
	logic [aip_pkg::OFFSET_W-1:0] end_q;
	logic                 stop_q;

	assign out_load = s2_valid_q && (!out_valid_q || results.ready);
	assign s2_free = !s2_valid_q || out_load;
	assign pop = head_valid && (!head.last || s2_free);

	always_comb begin
		phase_d = phase_q;
		acc_d = acc_q;
		neg_d = neg_q;
		base_d = base_q;
		endp_d = endp_q;
		ovf_d = ovf_q;
		pos_d = pos_inc(pos_q);
		begin_num = 1'b0;
		try_num = 1'b0;
		take = 1'b0;
		case (phase_q)
			aip_pkg::PH_SPACE: begin
				if (head.space) begin
					phase_d = aip_pkg::PH_SPACE;
				end else if (head.plus || head.minus) begin
					neg_d = head.minus;
					phase_d = aip_pkg::PH_SIGNED;
				end else begin
					begin_num = 1'b1;
				end
			end
			aip_pkg::PH_SIGNED: begin
				begin_num = 1'b1;
			end
			aip_pkg::PH_ZERO: begin
				if (head.hex_x) begin
					base_d = BASE_HEX;
					phase_d = aip_pkg::PH_HEXPFX;
				end else begin
					try_num = 1'b1;
				end
			end
			aip_pkg::PH_HEXPFX, aip_pkg::PH_DIGITS: begin
				try_num = 1'b1;
			end
			default: begin
				phase_d = aip_pkg::PH_DONE;
			end
		endcase

		base_use = base_q;
		if (begin_num) begin
			if (number_base == '0) begin
				base_use = head.zero ? BASE_OCT : BASE_DEC;
			end else begin
				base_use = number_base;
			end
			base_d = base_use;
			if (head.zero && (number_base == '0 || number_base == BASE_HEX)) begin
				take = 1'b1;
				phase_d = aip_pkg::PH_ZERO;
			end else begin
				try_num = 1'b1;
			end
		end

		if (try_num) begin
			if (base_use >= BASE_MIN && base_use <= BASE_MAX && head.alnum &&
					head.digit < base_use) begin
				take = 1'b1;
				phase_d = aip_pkg::PH_DIGITS;
			end else begin
				phase_d = aip_pkg::PH_DONE;
			end
		end

		lim = mag_limit(signed_mode, neg_q);
		prod = PROD_W'(acc_q) * PROD_W'(base_use) + PROD_W'(head.digit);
		if (take) begin
			if (!ovf_q) begin
				if (acc_q > lim || prod > PROD_W'(lim)) begin
					ovf_d = 1'b1;
				end else begin
					acc_d = prod[RES_W-1:0];
				end
			end
			endp_d = pos_inc(pos_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= aip_pkg::PH_SPACE;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			base_q  <= '0;
			pos_q   <= '0;
			endp_q  <= '0;
			ovf_q   <= 1'b0;
		end else if (pop) begin
			if (head.last) begin
				phase_q <= aip_pkg::PH_SPACE;
				acc_q   <= '0;
				neg_q   <= 1'b0;
				base_q  <= '0;
				pos_q   <= '0;
				endp_q  <= '0;
				ovf_q   <= 1'b0;
			end else begin
				phase_q <= phase_d;
				acc_q   <= acc_d;
				neg_q   <= neg_d;
				base_q  <= base_d;
				pos_q   <= pos_d;
				endp_q  <= endp_d;
				ovf_q   <= ovf_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.last) begin
			acc_s2 <= acc_d;
			neg_s2 <= neg_d;
			ovf_s2 <= ovf_d;
			sgn_s2 <= signed_mode;
			bad_s2 <= base_bad(number_base) || base_bad(base_d);
			end_s2 <= endp_d;
			cnt_s2 <= pos_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (pop && head.last) begin
			s2_valid_q <= 1'b1;
		end else if (out_load) begin
			s2_valid_q <= 1'b0;
		end
	end

	// The clamp value of an overflow equals the magnitude limit in every mode.
	always_comb begin
		lim_s2 = mag_limit(sgn_s2, neg_s2);
		fin_value = '0;
		fin_end = '0;
		if (bad_s2) begin
			fin_status = aip_pkg::ST_BAD_BASE;
		end else if (end_s2 == '0) begin
			fin_status = aip_pkg::ST_NO_DIGITS;
		end else if (ovf_s2 || acc_s2 > lim_s2) begin
			fin_status = aip_pkg::ST_OVERFLOW;
			fin_value = lim_s2;
			fin_end = end_s2;
		end else begin
			fin_status = aip_pkg::ST_OK;
			fin_value = (sgn_s2 && neg_s2) ? RES_W'(0) - acc_s2 : acc_s2;
			fin_end = end_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			value_q  <= fin_value;
			status_q <= fin_status;
			end_q    <= aip_pkg::OFFSET_W'(fin_end);
			stop_q   <= (fin_end != cnt_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign results.valid = out_valid_q;
	assign results.value = value_q;
	assign results.status = status_q;
	assign results.end_offset = end_q;
	assign results.stopped_early = stop_q;

	`AIP_ASSERT_NEXT(a_clear_after_last, pop && head.last, phase_q == aip_pkg::PH_SPACE && acc_q == '0 && pos_q == '0, "parse state not cleared after last character")
	`AIP_ASSERT_IMPLY(a_ovf_has_end, ovf_q, endp_q != '0, "overflow flagged without a consumed digit")
	`AIP_ASSERT_IMPLY(a_digit_phase_has_end, phase_q == aip_pkg::PH_ZERO || phase_q == aip_pkg::PH_HEXPFX || phase_q == aip_pkg::PH_DIGITS, endp_q != '0, "digit phase without a recorded end")
	`AIP_ASSERT_IMPLY(a_empty_result_clean, out_valid_q && (status_q == aip_pkg::ST_NO_DIGITS || status_q == aip_pkg::ST_BAD_BASE), value_q == '0 && end_q == '0, "failed parse carries a value or end offset")
	`AIP_ASSERT_NEXT(a_s2_hold, s2_valid_q && !out_load, s2_valid_q && $stable(acc_s2), "result stage lost while output stalled")

endmodule

// ===== src/ascii_integer_parser.sv =====
// Top level of the streaming ASCII-to-integer parser.
// The chars channel carries one byte per transfer, with last_char set on the final
// byte of a string. Each string yields exactly one transfer on the results channel:
// the parsed value, a status (ok, no digits, overflow clamped, invalid base), the
// offset of the first unconsumed byte and a flag for bytes left unconsumed.
// The configuration port writes number_base (index 0) and signed_mode (index 1);
// write them only while no string is in flight.
// A byte is taken every cycle while the queue is not full. The parse engine
// multiplies the accumulator by the base and adds one digit per cycle, so that
// loop sets the rate of one byte a cycle. A two-entry queue decouples the front
// end from the parse engine, and a result stage plus an output register let bytes
// of the next string flow while a result waits for the receiver. When the receiver
// stalls, the output holds, the result stage fills, and the queue fills behind a
// last byte, which drops chars.ready.
// Reset clears the parse state, empties the queue and output, and sets both
// configuration registers to zero.
module ascii_integer_parser (
	input  logic                             clk,
	input  logic                             arst_n,
	aip_char_if.sink                         chars,
	aip_result_if.source                     results,
	input  logic                             cfg_we,
	input  logic [aip_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [aip_pkg::CFG_DATA_W-1:0]   cfg_data
);

	logic [aip_pkg::BASE_W-1:0] number_base_q;
	logic                       signed_mode_q;

	logic          push;
	logic          full;
	logic          pop;
	logic          head_valid;
	aip_pkg::cls_t push_item;
	aip_pkg::cls_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_base_q <= '0;
			signed_mode_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				aip_pkg::CFG_NUMBER_BASE: number_base_q <= cfg_data[aip_pkg::BASE_W-1:0];
				aip_pkg::CFG_SIGNED_MODE: signed_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	aip_front u_front (
		.chars (chars),
		.full  (full),
		.push  (push),
		.item  (push_item)
	);

	aip_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	aip_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop),
		.number_base (number_base_q),
		.signed_mode (signed_mode_q),
		.results     (results)
	);

endmodule
